// ===== design/cgc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cgc_pkg;

  // Default sizes of the coloring engine.
  localparam int CGC_NUM_COLORS      = 24;
  localparam int CGC_MAX_BODIES      = 1024;
  localparam int CGC_MAX_CONSTRAINTS = 4096;

  // Fixed widths of the channel fields.
  localparam int BODY_W   = 10;
  localparam int COLOR_W  = 5;
  localparam int RANK_W   = 12;
  localparam int BIDX_W   = 5;
  localparam int BSTART_W = 13;

  // Depth of the queue between the front and the back; a power of two.
  localparam int CGC_QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic KIND_COLOR  = 1'b0;
  localparam logic KIND_BUCKET = 1'b1;

  // Commands carried by an input word.
  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [BODY_W-1:0] body_a;
    logic [BODY_W-1:0] body_b;
    logic              mov_a;
    logic              mov_b;
  } cgc_op_t;

  // States of the back-end sequencer.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COLOR,
    ST_WRITE_B,
    ST_EMIT
  } cgc_state_t;

endpackage

`default_nettype wire

// ===== design/cgc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one constraint or a finish command per word.
interface cgc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [9:0] body_a;
  logic [9:0] body_b;
  logic       a_movable;
  logic       b_movable;

  modport source (output valid, cmd, body_a, body_b, a_movable, b_movable, input ready);
  modport sink   (input valid, cmd, body_a, body_b, a_movable, b_movable, output ready);
endinterface

// Result channel: a color result or a bucket start per word.
interface cgc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  color;
  logic [11:0] rank;
  logic [4:0]  bucket_index;
  logic [12:0] bucket_start;
  logic        last;

  modport source (output valid, kind, color, rank, bucket_index, bucket_start, last,
                  input ready);
  modport sink   (input valid, kind, color, rank, bucket_index, bucket_start, last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/constraint_graph_coloring_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Word contents
// in_ch    sink       cmd, body_a, body_b, a_movable, b_movable
// out_ch   source     kind, color, rank, bucket_index, bucket_start, last
//
// An add passes through the back-end state ST_COLOR, and also ST_WRITE_B when
// the second body is movable and a color is found; the single write port of the
// body mask memory sets this. A finish gives NUM_COLORS+2 words, one per cycle
// unless out_ch stalls, then a clearing pass over all MAX_BODIES mask entries.
// Reset starts the same clearing pass. The front and a short queue keep taking
// words while the back works or the result register waits on out_ch.ready.
module constraint_graph_coloring_unit #(
  parameter int NUM_COLORS      = cgc_pkg::CGC_NUM_COLORS,
  parameter int MAX_BODIES      = cgc_pkg::CGC_MAX_BODIES,
  parameter int MAX_CONSTRAINTS = cgc_pkg::CGC_MAX_CONSTRAINTS
) (
  input  wire        clk,
  input  wire        rst_n,
  cgc_in_if.sink     in_ch,
  cgc_out_if.source  out_ch
);
  import cgc_pkg::*;

  logic    q_push_valid;
  logic    q_push_ready;
  cgc_op_t q_push_op;
  logic    q_pop_valid;
  logic    q_pop_ready;
  cgc_op_t q_pop_op;

  // Front end: accept and classify.
  cgc_front #(
    .MAX_BODIES (MAX_BODIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op)
  );

  // Queue between front and back.
  cgc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_op    (q_push_op),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_op     (q_pop_op)
  );

  // Back end: coloring, bucket counts and result register.
  cgc_back #(
    .NUM_COLORS      (NUM_COLORS),
    .MAX_BODIES      (MAX_BODIES),
    .MAX_CONSTRAINTS (MAX_CONSTRAINTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_op    (q_pop_op),
    .out_ch    (out_ch)
  );

  // Right after reset nothing is shown and the back is busy clearing.
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_ch.valid && !q_pop_ready))
    else $error("result or queue pop active right after reset");

  // A finish keeps the back from taking the next item in the following cycle.
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_valid && q_pop_ready && q_pop_op.op == OP_FINISH) |=> !q_pop_ready)
    else $error("back took an item right after a finish");

  // While bucket starts are still going out, no item is taken.
  a_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_BUCKET && !out_ch.last) |-> !q_pop_ready)
    else $error("item taken during bucket start output");

endmodule

`default_nettype wire

// ===== design/cgc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cgc_front #(
  parameter int MAX_BODIES = cgc_pkg::CGC_MAX_BODIES
) (
  input  wire              clk,
  input  wire              rst_n,
  cgc_in_if.sink           in_ch,
  output logic             push_valid,
  input  wire              push_ready,
  output cgc_pkg::cgc_op_t push_op
);
  import cgc_pkg::*;

  logic    hold_valid_r;
  cgc_op_t hold_op_r;
  cgc_op_t op_nxt;

  // Decode the command and mark a side movable only when its index is in range.
  always_comb begin
    op_nxt.op     = op_t'(in_ch.cmd);
    op_nxt.body_a = in_ch.body_a;
    op_nxt.body_b = in_ch.body_b;
    op_nxt.mov_a  = in_ch.a_movable && (32'(in_ch.body_a) < MAX_BODIES);
    op_nxt.mov_b  = in_ch.b_movable && (32'(in_ch.body_b) < MAX_BODIES);
  end

  assign in_ch.ready = !hold_valid_r || push_ready;
  assign push_valid  = hold_valid_r;
  assign push_op     = hold_op_r;

  // One holding stage in front of the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_op_r <= op_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/cgc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cgc_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  cgc_pkg::cgc_op_t push_op,
  output logic             pop_valid,
  input  wire              pop_ready,
  output cgc_pkg::cgc_op_t pop_op
);
  import cgc_pkg::*;

  localparam int PW = $clog2(CGC_QUEUE_DEPTH) + 1;

  cgc_op_t       entries_r [CGC_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic          full;
  logic          empty;

  // Pointers carry one wrap bit to tell full from empty.
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[PW-1] != rd_ptr_r[PW-1]) &&
                 (wr_ptr_r[PW-2:0] == rd_ptr_r[PW-2:0]);

  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_op     = entries_r[rd_ptr_r[PW-2:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push_valid && push_ready) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop_valid && pop_ready) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      entries_r[wr_ptr_r[PW-2:0]] <= push_op;
    end
  end

endmodule

`default_nettype wire

// ===== design/cgc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cgc_back #(
  parameter int NUM_COLORS      = cgc_pkg::CGC_NUM_COLORS,
  parameter int MAX_BODIES      = cgc_pkg::CGC_MAX_BODIES,
  parameter int MAX_CONSTRAINTS = cgc_pkg::CGC_MAX_CONSTRAINTS
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              pop_valid,
  output logic             pop_ready,
  input  cgc_pkg::cgc_op_t pop_op,
  cgc_out_if.source        out_ch
);
  import cgc_pkg::*;

  localparam int MW   = NUM_COLORS;
  localparam int AW   = $clog2(MAX_BODIES);
  localparam int CIW  = $clog2(NUM_COLORS + 2);
  localparam int BKW  = $clog2(NUM_COLORS + 1);
  localparam int CNTW = $clog2(MAX_CONSTRAINTS + 1);

  cgc_state_t state_r, state_nxt;

  // Body color mask memory: one write port, two registered read ports.
  logic [MW-1:0] mask_mem [MAX_BODIES];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra_a;
  logic [AW-1:0] mem_ra_b;
  logic [MW-1:0] mask_a_r;
  logic [MW-1:0] mask_b_r;

  logic [AW-1:0]   addr_a_r, addr_a_nxt;
  logic [AW-1:0]   addr_b_r, addr_b_nxt;
  logic            mov_a_r, mov_a_nxt;
  logic            mov_b_r, mov_b_nxt;
  logic [MW-1:0]   wb_data_r, wb_data_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [CIW-1:0]  emit_idx_r, emit_idx_nxt;
  logic [CNTW-1:0] cursor_r, cursor_nxt;
  logic [CNTW-1:0] total_r, total_nxt;
  logic [CNTW-1:0] counts_r [NUM_COLORS + 1];
  logic [CNTW-1:0] counts_nxt [NUM_COLORS + 1];

  logic              out_valid_r;
  logic              out_load;
  logic              out_free;
  logic              kind_r, kind_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic [BIDX_W-1:0]   bidx_r, bidx_nxt;
  logic [BSTART_W-1:0] bstart_r, bstart_nxt;
  logic                last_r, last_nxt;

  logic [MW-1:0]   mask_or;
  logic [CIW-1:0]  color_c;
  logic            color_ok;
  logic [MW-1:0]   color_bit;
  logic [CIW-1:0]  cnt_idx;
  logic [CNTW-1:0] cnt_rd;
  logic            at_capacity;
  logic            emit_last;
  logic            clr_done;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign at_capacity = (total_r >= CNTW'(MAX_CONSTRAINTS));
  assign emit_last   = (emit_idx_r == CIW'(NUM_COLORS + 1));
  assign clr_done    = (clr_addr_r == AW'(MAX_BODIES - 1));
  assign mem_ra_a    = AW'(pop_op.body_a);
  assign mem_ra_b    = AW'(pop_op.body_b);

  // Lowest free color over the masks of the movable sides.
  always_comb begin
    mask_or = (mov_a_r ? mask_a_r : '0) | (mov_b_r ? mask_b_r : '0);
    color_c = CIW'(NUM_COLORS);
    for (int i = NUM_COLORS - 1; i >= 0; i--) begin
      if (!mask_or[i]) begin
        color_c = CIW'(i);
      end
    end
    color_ok  = !(&mask_or);
    color_bit = MW'(1) << color_c;
  end

  // One read of the bucket counters, by color or by the emit index.
  assign cnt_idx = (state_r == ST_EMIT) ? emit_idx_r : color_c;
  assign cnt_rd  = counts_r[cnt_idx[BKW-1:0]];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_op.op == OP_FINISH) begin
            state_nxt = ST_EMIT;
          end else if (!at_capacity) begin
            state_nxt = ST_COLOR;
          end
        end
      end
      ST_COLOR: begin
        if (out_free) begin
          state_nxt = (mov_b_r && color_ok) ? ST_WRITE_B : ST_IDLE;
        end
      end
      ST_WRITE_B: begin
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_nxt = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Datapath and memory controls per state.
  always_comb begin
    pop_ready    = (state_r == ST_IDLE);
    mem_we       = 1'b0;
    mem_wa       = addr_a_r;
    mem_wd       = mask_a_r | color_bit;
    mem_re       = 1'b0;
    addr_a_nxt   = addr_a_r;
    addr_b_nxt   = addr_b_r;
    mov_a_nxt    = mov_a_r;
    mov_b_nxt    = mov_b_r;
    wb_data_nxt  = wb_data_r;
    clr_addr_nxt = clr_addr_r;
    emit_idx_nxt = emit_idx_r;
    cursor_nxt   = cursor_r;
    total_nxt    = total_r;
    counts_nxt   = counts_r;
    out_load     = 1'b0;
    kind_nxt     = kind_r;
    color_nxt    = color_r;
    rank_nxt     = rank_r;
    bidx_nxt     = bidx_r;
    bstart_nxt   = bstart_r;
    last_nxt     = last_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        mem_wd       = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_op.op == OP_FINISH) begin
            emit_idx_nxt = '0;
            cursor_nxt   = '0;
          end else if (!at_capacity) begin
            mem_re     = 1'b1;
            addr_a_nxt = mem_ra_a;
            addr_b_nxt = mem_ra_b;
            mov_a_nxt  = pop_op.mov_a;
            mov_b_nxt  = pop_op.mov_b;
          end
        end
      end
      ST_COLOR: begin
        if (out_free) begin
          mem_we      = mov_a_r && color_ok;
          wb_data_nxt = mask_b_r | color_bit;
          counts_nxt[color_c[BKW-1:0]] = cnt_rd + CNTW'(1);
          total_nxt   = total_r + CNTW'(1);
          out_load    = 1'b1;
          kind_nxt    = KIND_COLOR;
          color_nxt   = COLOR_W'(color_c);
          rank_nxt    = RANK_W'(cnt_rd);
          bidx_nxt    = '0;
          bstart_nxt  = '0;
          last_nxt    = 1'b1;
        end
      end
      ST_WRITE_B: begin
        mem_we = 1'b1;
        mem_wa = addr_b_r;
        mem_wd = wb_data_r;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          kind_nxt     = KIND_BUCKET;
          color_nxt    = '0;
          rank_nxt     = '0;
          bidx_nxt     = BIDX_W'(emit_idx_r);
          bstart_nxt   = BSTART_W'(cursor_r);
          last_nxt     = emit_last;
          emit_idx_nxt = emit_idx_r + CIW'(1);
          if (emit_last) begin
            total_nxt    = '0;
            clr_addr_nxt = '0;
          end else begin
            // Each bucket is cleared as its start goes out.
            cursor_nxt = cursor_r + cnt_rd;
            counts_nxt[emit_idx_r[BKW-1:0]] = '0;
          end
        end
      end
      default: begin
        pop_ready = 1'b0;
      end
    endcase
  end

  // Mask memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mask_a_r <= mask_mem[mem_ra_a];
      mask_b_r <= mask_mem[mem_ra_b];
    end
  end

  // Control state and bucket counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= NUM_COLORS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      total_r    <= total_nxt;
      counts_r   <= counts_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    addr_a_r   <= addr_a_nxt;
    addr_b_r   <= addr_b_nxt;
    mov_a_r    <= mov_a_nxt;
    mov_b_r    <= mov_b_nxt;
    wb_data_r  <= wb_data_nxt;
    emit_idx_r <= emit_idx_nxt;
    cursor_r   <= cursor_nxt;
    kind_r     <= kind_nxt;
    color_r    <= color_nxt;
    rank_r     <= rank_nxt;
    bidx_r     <= bidx_nxt;
    bstart_r   <= bstart_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.color        = color_r;
  assign out_ch.rank         = rank_r;
  assign out_ch.bucket_index = bidx_r;
  assign out_ch.bucket_start = bstart_r;
  assign out_ch.last         = last_r;

endmodule

`default_nettype wire
